// ----- rtl/core/token_fold_region_matcher_core_assert.svh -----
// Assertion macros for the token fold region matcher.
// Included by the matcher core to check its own logic; no other dependencies.
`ifndef TOKEN_FOLD_REGION_MATCHER_CORE_ASSERT_SVH
`define TOKEN_FOLD_REGION_MATCHER_CORE_ASSERT_SVH

// Check a condition on every rising clock edge outside reset.
`define TFRM_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: %m");

// Check a consequence in the same cycle as its cause.
`define TFRM_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: %m");

// Check a consequence in the cycle after its cause.
`define TFRM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: %m");

`endif

// ----- rtl/core/tfrm_pkg.sv -----
// Shared types and constants of the token fold region matcher.
// No dependencies; imported by every module of the block.
package tfrm_pkg;

   localparam int OFF_W  = 32;
   localparam int LINE_W = 24;

   localparam int REQ_DATA_W = 144;
   localparam int REQ_USER_W = 4;
   localparam int RSP_DATA_W = 64;
   localparam int RSP_USER_W = 2;

   // Block comment markers: two characters open, two close.
   localparam logic [OFF_W-1:0] COMMENT_OPEN_LEN = OFF_W'(2);
   localparam logic [OFF_W-1:0] TRIM_TERM        = OFF_W'(4);
   localparam logic [OFF_W-1:0] TRIM_UNTERM      = OFF_W'(2);

   localparam logic PH_BRACE = 1'b0;
   localparam logic PH_GROUP = 1'b1;

   typedef enum logic [2:0] {
      KIND_OTHER     = 3'd0,
      KIND_OPEN      = 3'd1,
      KIND_CLOSE     = 3'd2,
      KIND_COMMENT   = 3'd3,
      KIND_IF        = 3'd4,
      KIND_ELSE      = 3'd5,
      KIND_ENDIF     = 3'd6,
      KIND_OTHER_DIR = 3'd7
   } tfrm_kind_type;

   // One stack entry: line in the upper bits, offset in the lower bits.
   typedef struct packed {
      logic [LINE_W-1:0] line;
      logic [OFF_W-1:0]  off;
   } tfrm_entry_type;

   // Request tdata layout, lowest field last.
   typedef struct packed {
      logic [OFF_W-1:0]  dle;
      logic [LINE_W-1:0] eline;
      logic [LINE_W-1:0] sline;
      logic [OFF_W-1:0]  len;
      logic [OFF_W-1:0]  off;
   } tfrm_req_data_type;

   // Response tdata layout, lowest field last.
   typedef struct packed {
      logic [OFF_W-1:0] len;
      logic [OFF_W-1:0] start;
   } tfrm_rsp_data_type;

   // Token as it waits for its stack read to return.
   typedef struct packed {
      tfrm_kind_type     kind;
      logic [OFF_W-1:0]  off;
      logic [OFF_W-1:0]  len;
      logic [LINE_W-1:0] sline;
      logic [LINE_W-1:0] eline;
      logic              unterm;
      logic              pop_hit;
      logic              ovf;
   } tfrm_tok_type;

endpackage

// ----- rtl/core/tfrm_stack_mem.sv -----
// Synchronous stack storage: one write port, one registered read port.
// Depends on tfrm_pkg for the entry type.
module tfrm_stack_mem #(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  tfrm_pkg::tfrm_entry_type wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output tfrm_pkg::tfrm_entry_type rd_data
);
   import tfrm_pkg::*;

   tfrm_entry_type mem_ff [DEPTH];
   tfrm_entry_type rd_data_ff;

   // Read returns the old contents when the same entry is written in that cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/tfrm_fold_eval.sv -----
// Fold decision on a popped entry or a block comment, and the result register.
// Depends on tfrm_pkg for token, entry and response types.
module tfrm_fold_eval (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          s1_valid,
   input  tfrm_pkg::tfrm_tok_type        s1_tok,
   input  tfrm_pkg::tfrm_entry_type      brace_top,
   input  tfrm_pkg::tfrm_entry_type      group_top,
   output logic                          s1_adv,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [tfrm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [tfrm_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import tfrm_pkg::*;

   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [OFF_W-1:0] start_ff;
   logic [OFF_W-1:0] flen_ff;
   logic             pkind_ff;
   logic             ovf_ff;

   logic             emit;
   logic [OFF_W-1:0] start_c;
   logic [OFF_W-1:0] flen_c;
   logic             pkind_c;
   logic [OFF_W-1:0] trim;
   tfrm_entry_type   top_sel;
   tfrm_rsp_data_type rsp_data;

   always_comb begin
      emit    = 1'b0;
      start_c = '0;
      flen_c  = '0;
      pkind_c = PH_BRACE;
      trim    = s1_tok.unterm ? TRIM_UNTERM : TRIM_TERM;
      top_sel = (s1_tok.kind == KIND_CLOSE) ? brace_top : group_top;
      case (s1_tok.kind) inside
         KIND_CLOSE, KIND_ELSE, KIND_ENDIF: begin
            pkind_c = (s1_tok.kind == KIND_CLOSE) ? PH_BRACE : PH_GROUP;
            emit    = s1_tok.pop_hit && (s1_tok.sline > top_sel.line) &&
                      (s1_tok.off > top_sel.off);
            start_c = top_sel.off;
            flen_c  = s1_tok.off - top_sel.off;
         end
         KIND_COMMENT: begin
            emit    = (s1_tok.eline > s1_tok.sline) && (s1_tok.len > trim);
            start_c = s1_tok.off + COMMENT_OPEN_LEN;
            flen_c  = s1_tok.len - trim;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // Move the waiting token on whenever the result register is free or being taken.
   assign s1_adv       = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = s1_adv ? (s1_valid && emit) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s1_adv) begin
         start_ff <= start_c;
         flen_ff  <= flen_c;
         pkind_ff <= pkind_c;
         ovf_ff   <= s1_tok.ovf;
      end
   end

   assign rsp_data.start = start_ff;
   assign rsp_data.len   = flen_ff;
   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_tdata      = rsp_data;
   assign rsp_tuser      = {ovf_ff, pkind_ff};

endmodule

// ----- rtl/core/token_fold_region_matcher_core.sv -----
// Token fold region matcher: one token per cycle unless stalled; the result is registered.
// Stack reads issue at acceptance; the registered read data is evaluated the next cycle.
// Unstalled rate is one token per clock, set by the single push/pop per stack memory.
// Reset clears stack counts, the sticky overflow flag and all valid bits; stack
// memories are not cleared, as entries above the count are never used.
module token_fold_region_matcher_core #(
   parameter int BRACE_DEPTH = 64,
   parameter int GROUP_DEPTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   // tdata: token_offset[31:0], token_length[63:32], start_line[87:64],
   //        end_line[111:88], directive_line_end[143:112]
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [tfrm_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: token_kind[2:0], unterminated[3]
   input  logic [tfrm_pkg::REQ_USER_W-1:0] req_tuser,
   // tdata: fold_start[31:0], fold_length[63:32]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [tfrm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // tuser: placeholder_kind[0], overflow_seen[1]
   output logic [tfrm_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import tfrm_pkg::*;

   localparam int BAW = $clog2(BRACE_DEPTH);
   localparam int BCW = $clog2(BRACE_DEPTH + 1);
   localparam int GAW = $clog2(GROUP_DEPTH);
   localparam int GCW = $clog2(GROUP_DEPTH + 1);

   // Stack pointers and sticky overflow
   logic [BCW-1:0] bcount_ff, bcount_in;
   logic [GCW-1:0] gcount_ff, gcount_in;
   logic           ovf_ff, ovf_in;

   // Token waiting on its stack read
   logic           s1_valid_ff, s1_valid_in;
   tfrm_tok_type   s1_tok_ff, s1_tok_in;
   logic           s1_adv;

   tfrm_req_data_type req;
   tfrm_kind_type     kind;
   logic              accept;

   logic           b_push, b_pop, b_full, b_wr;
   logic           g_push, g_pop, g_full, g_wr;
   logic [BCW-1:0] bcount_dec;
   logic [GCW-1:0] gcount_dec, gcount_pop;
   tfrm_entry_type b_wr_data, g_wr_data;
   tfrm_entry_type brace_top, group_top;

   assign req    = req_tdata;
   assign kind   = tfrm_kind_type'(req_tuser[2:0]);
   assign accept = req_tvalid && req_tready;

   // Take a new token when the stage ahead is empty or moving on.
   assign req_tready = !s1_valid_ff || s1_adv;

   // Brace stack: push the offset just past the opener, pop on a closer.
   assign b_push     = (kind == KIND_OPEN);
   assign b_full     = (bcount_ff == BCW'(BRACE_DEPTH));
   assign b_pop      = (kind == KIND_CLOSE) && (bcount_ff != '0);
   assign b_wr       = accept && b_push && !b_full;
   assign bcount_dec = bcount_ff - BCW'(1);
   assign b_wr_data.off  = req.off + req.len;
   assign b_wr_data.line = req.sline;

   // Group stack: else pops first, then pushes into the freed slot.
   assign g_pop      = ((kind == KIND_ELSE) || (kind == KIND_ENDIF)) && (gcount_ff != '0);
   assign gcount_dec = gcount_ff - GCW'(1);
   assign gcount_pop = g_pop ? gcount_dec : gcount_ff;
   assign g_push     = (kind == KIND_IF) || (kind == KIND_ELSE);
   assign g_full     = (gcount_pop == GCW'(GROUP_DEPTH));
   assign g_wr       = accept && g_push && !g_full;
   assign g_wr_data.off  = req.dle;
   assign g_wr_data.line = req.sline;

   always_comb begin
      bcount_in = bcount_ff;
      gcount_in = gcount_ff;
      ovf_in    = ovf_ff;
      if (accept) begin
         if (b_wr) begin
            bcount_in = bcount_ff + BCW'(1);
         end else if (b_pop) begin
            bcount_in = bcount_dec;
         end
         gcount_in = g_wr ? (gcount_pop + GCW'(1)) : gcount_pop;
         // Set overflow on any dropped push; it holds until reset.
         if ((b_push && b_full) || (g_push && g_full)) begin
            ovf_in = 1'b1;
         end
      end
   end

   always_comb begin
      s1_valid_in       = req_tready ? req_tvalid : s1_valid_ff;
      s1_tok_in.kind    = kind;
      s1_tok_in.off     = req.off;
      s1_tok_in.len     = req.len;
      s1_tok_in.sline   = req.sline;
      s1_tok_in.eline   = req.eline;
      s1_tok_in.unterm  = req_tuser[3];
      s1_tok_in.pop_hit = b_pop || g_pop;
      s1_tok_in.ovf     = ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bcount_ff   <= '0;
         gcount_ff   <= '0;
         ovf_ff      <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         bcount_ff   <= bcount_in;
         gcount_ff   <= gcount_in;
         ovf_ff      <= ovf_in;
         s1_valid_ff <= s1_valid_in;
      end
      if (accept) begin
         s1_tok_ff <= s1_tok_in;
      end
   end

   // Read the top entry on every accepted token; the read data holds while stalled.
   tfrm_stack_mem #(
      .DEPTH (BRACE_DEPTH)
   ) u_brace_mem (
      .clock   (clock),
      .wr_en   (b_wr),
      .wr_addr (bcount_ff[BAW-1:0]),
      .wr_data (b_wr_data),
      .rd_en   (accept),
      .rd_addr (bcount_dec[BAW-1:0]),
      .rd_data (brace_top)
   );

   tfrm_stack_mem #(
      .DEPTH (GROUP_DEPTH)
   ) u_group_mem (
      .clock   (clock),
      .wr_en   (g_wr),
      .wr_addr (gcount_pop[GAW-1:0]),
      .wr_data (g_wr_data),
      .rd_en   (accept),
      .rd_addr (gcount_dec[GAW-1:0]),
      .rd_data (group_top)
   );

   tfrm_fold_eval u_fold_eval (
      .clock      (clock),
      .reset      (reset),
      .s1_valid   (s1_valid_ff),
      .s1_tok     (s1_tok_ff),
      .brace_top  (brace_top),
      .group_top  (group_top),
      .s1_adv     (s1_adv),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

`include "token_fold_region_matcher_core_assert.svh"

   `TFRM_ASSERT_ALWAYS(a_brace_bound, clock, reset, bcount_ff <= BCW'(BRACE_DEPTH))
   `TFRM_ASSERT_ALWAYS(a_group_bound, clock, reset, gcount_ff <= GCW'(GROUP_DEPTH))
   `TFRM_ASSERT_NEXT(a_ovf_sticky, clock, reset, ovf_ff, ovf_ff)
   `TFRM_ASSERT_IMPLIES(a_stall_blocks, clock, reset, s1_valid_ff && rsp_tvalid && !rsp_tready, !req_tready)

endmodule
